/* hw/rtl/cmr_pkg.sv */
// Shared types and constants for the CAN message reassembler.
// No dependencies; every other file of the block imports this package.
package cmr_pkg;

    localparam int SEG_BYTES = 7;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 7;
    localparam int CHUNK_W   = 5;
    localparam int LEN_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int SEG_DATA_W = SEG_BYTES * BYTE_W;

    typedef logic [SEG_DATA_W-1:0] t_seg_data;

    // Result status codes as they appear on the output channel.
    typedef enum logic [STATUS_W-1:0] {
        STAT_STORED     = 2'd0,
        STAT_OVERFLOW   = 2'd1,
        STAT_INCOMPLETE = 2'd2,
        STAT_COMPLETE   = 2'd3
    } t_status;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_CHECK,
        S_READ,
        S_SEND,
        S_REPLY
    } t_state;

    // Commands to the received-segment mark register.
    typedef struct packed {
        logic set;      // mark one segment as received
        logic restart;  // with set: drop all other marks first
        logic clear;    // drop all marks
    } t_mark_ctl;

endpackage

/* hw/rtl/cmr_if.sv */
// Valid/ready channel interfaces for the CAN message reassembler.
// Depends on cmr_pkg for the field widths.
interface cmr_in_if import cmr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  seg_index;
    logic              end_flag;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic [BYTE_W-1:0] byte3;
    logic [BYTE_W-1:0] byte4;
    logic [BYTE_W-1:0] byte5;
    logic [BYTE_W-1:0] byte6;

    modport source (
        output valid, seg_index, end_flag, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
        input  ready
    );
    modport sink (
        input  valid, seg_index, end_flag, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
        output ready
    );
endinterface

interface cmr_out_if import cmr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CHUNK_W-1:0]  chunk_index;
    logic [BYTE_W-1:0]   out0;
    logic [BYTE_W-1:0]   out1;
    logic [BYTE_W-1:0]   out2;
    logic [BYTE_W-1:0]   out3;
    logic [BYTE_W-1:0]   out4;
    logic [BYTE_W-1:0]   out5;
    logic [BYTE_W-1:0]   out6;
    logic [LEN_W-1:0]    message_length;
    logic                last;

    modport source (
        output valid, status, chunk_index, out0, out1, out2, out3, out4, out5, out6,
               message_length, last,
        input  ready
    );
    modport sink (
        input  valid, status, chunk_index, out0, out1, out2, out3, out4, out5, out6,
               message_length, last,
        output ready
    );
endinterface

/* hw/rtl/cmr_seg_mem.sv */
// Segment store: one write port and one read port with registered read data.
// Depends on cmr_pkg for the segment data type.
module cmr_seg_mem import cmr_pkg::*; #(
    parameter int DEPTH  = 18,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_seg_data         i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_seg_data         o_rd_data
);

    t_seg_data r_mem [DEPTH];
    t_seg_data r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/cmr_marks.sv */
// Received-segment mark register with one bit read port for the scan.
// Depends on cmr_pkg for the command struct.
module cmr_marks import cmr_pkg::*; #(
    parameter int NSEG  = 18,
    parameter int SEG_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mark_ctl        i_ctl,
    input  logic [SEG_W-1:0] i_set_idx,
    input  logic [SEG_W-1:0] i_rd_idx,
    output logic             o_rd_mark
);

    logic [NSEG-1:0] r_marks;
    logic [NSEG-1:0] n_marks;

    always_comb begin
        n_marks = r_marks;
        if (i_ctl.clear) begin
            n_marks = '0;
        end else if (i_ctl.set) begin
            if (i_ctl.restart) begin
                n_marks = '0;
            end
            n_marks[i_set_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
        end else begin
            r_marks <= n_marks;
        end
    end

    assign o_rd_mark = r_marks[i_rd_idx];

endmodule

/* hw/rtl/can_message_reassembler_unit.sv */
// Top level of the CAN message reassembler: sequencer and output register.
// Depends on cmr_pkg, cmr_if, cmr_seg_mem and cmr_marks.
//
// The block takes one CAN frame per input transfer (segment index, end flag
// and seven payload bytes) and works on it alone; the input is ready only
// while the sequencer is idle. A segment at or beyond MAX_BYTES/7 is dropped
// and answered with an overflow status. Any other segment is written to the
// segment memory and marked as received; segment 0 drops all older marks.
// A frame without the end flag is answered with a stored status. On an end
// frame a single mark reader walks the marks from segment 0 to the end index,
// one per cycle, and stops at the first gap with an incomplete status. If all
// are present, the segments are read back from the memory one at a time and
// sent as complete-segment results carrying the message length
// (index + 1) * 7, the last one flagged. All marks are cleared after an end
// frame that is in range. Each segment is read from the memory and then loaded
// into the output register; a result that the sink has not yet taken holds
// the sequencer until the output register is free. The memory needs no
// clearing after reset.
module can_message_reassembler_unit import cmr_pkg::*; #(
    parameter int MAX_BYTES = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cmr_in_if.sink    i_in,
    cmr_out_if.source o_out
);

    localparam int NSEG       = MAX_BYTES / SEG_BYTES;
    localparam int SEG_W      = (NSEG > 1) ? $clog2(NSEG) : 1;
    localparam int LEN_FULL_W = SEG_W + 3;
    localparam logic [IDX_W:0] NSEG_LIM = (IDX_W + 1)'(NSEG);

    // Sequencer and captured frame.
    t_state           r_state;
    t_state           n_state;
    logic [SEG_W-1:0] r_idx;
    logic             r_end;
    logic             r_in_range;
    t_seg_data        r_data;
    logic [SEG_W-1:0] r_cnt;
    logic [SEG_W-1:0] n_cnt;
    t_status          r_status;
    t_status          n_status;

    // Output register.
    logic                r_out_valid;
    t_status             r_o_status;
    logic [CHUNK_W-1:0]  r_o_chunk;
    t_seg_data           r_o_data;
    logic [LEN_W-1:0]    r_o_len;
    logic                r_o_last;

    logic                  w_accept;
    logic                  w_slot_free;
    logic                  w_load;
    logic                  w_send;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic                  w_rd_mark;
    t_mark_ctl             w_mark_ctl;
    t_seg_data             w_rd_data;
    logic [LEN_FULL_W-1:0] w_len_full;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || o_out.ready;

    // Message length is (end index + 1) * 7, kept to the field width.
    assign w_len_full = (LEN_FULL_W'(r_idx) + LEN_FULL_W'(1)) * LEN_FULL_W'(SEG_BYTES);

    cmr_seg_mem #(
        .DEPTH  (NSEG),
        .ADDR_W (SEG_W)
    ) u_seg_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (r_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_cnt),
        .o_rd_data (w_rd_data)
    );

    cmr_marks #(
        .NSEG  (NSEG),
        .SEG_W (SEG_W)
    ) u_marks (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mark_ctl),
        .i_set_idx (r_idx),
        .i_rd_idx  (r_cnt),
        .o_rd_mark (w_rd_mark)
    );

    // Next state and control for the sequencer.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_status   = r_status;
        w_mark_ctl = '0;
        w_wr_en    = 1'b0;
        w_rd_en    = 1'b0;
        w_load     = 1'b0;
        w_send     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (!r_in_range) begin
                    n_status = STAT_OVERFLOW;
                    n_state  = S_REPLY;
                end else begin
                    w_wr_en            = 1'b1;
                    w_mark_ctl.set     = 1'b1;
                    w_mark_ctl.restart = (r_idx == '0);
                    if (!r_end) begin
                        n_status = STAT_STORED;
                        n_state  = S_REPLY;
                    end else begin
                        n_cnt   = '0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // One mark per cycle, from segment 0 up to the end index.
                if (!w_rd_mark) begin
                    w_mark_ctl.clear = 1'b1;
                    n_status         = STAT_INCOMPLETE;
                    n_state          = S_REPLY;
                end else if (r_cnt == r_idx) begin
                    w_mark_ctl.clear = 1'b1;
                    n_cnt            = '0;
                    n_state          = S_READ;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_READ: begin
                w_rd_en = 1'b1;
                n_state = S_SEND;
            end
            S_SEND: begin
                if (w_slot_free) begin
                    w_load = 1'b1;
                    w_send = 1'b1;
                    if (r_cnt == r_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_REPLY: begin
                if (w_slot_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_status <= n_status;
        if (w_accept) begin
            r_idx      <= i_in.seg_index[SEG_W-1:0];
            r_end      <= i_in.end_flag;
            r_in_range <= ({1'b0, i_in.seg_index} < NSEG_LIM);
            r_data     <= {i_in.byte6, i_in.byte5, i_in.byte4, i_in.byte3,
                           i_in.byte2, i_in.byte1, i_in.byte0};
        end
    end

    // The output register holds one result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_send) begin
                r_o_status <= STAT_COMPLETE;
                r_o_chunk  <= CHUNK_W'(r_cnt);
                r_o_data   <= w_rd_data;
                r_o_len    <= w_len_full[LEN_W-1:0];
                r_o_last   <= (r_cnt == r_idx);
            end else begin
                r_o_status <= r_status;
                r_o_chunk  <= '0;
                r_o_data   <= '0;
                r_o_len    <= '0;
                r_o_last   <= 1'b1;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_o_status;
    assign o_out.chunk_index    = r_o_chunk;
    assign o_out.out0           = r_o_data[0*BYTE_W +: BYTE_W];
    assign o_out.out1           = r_o_data[1*BYTE_W +: BYTE_W];
    assign o_out.out2           = r_o_data[2*BYTE_W +: BYTE_W];
    assign o_out.out3           = r_o_data[3*BYTE_W +: BYTE_W];
    assign o_out.out4           = r_o_data[4*BYTE_W +: BYTE_W];
    assign o_out.out5           = r_o_data[5*BYTE_W +: BYTE_W];
    assign o_out.out6           = r_o_data[6*BYTE_W +: BYTE_W];
    assign o_out.message_length = r_o_len;
    assign o_out.last           = r_o_last;

endmodule
